### src/pdda_pkg.sv
// Shared types, constants and saturation helpers for the PID core.
// No dependencies; used by pdda_alu and pid_dirty_derivative_antiwindup_core.
package pdda_pkg;

  // Operand and result widths of the serial arithmetic unit
  localparam int MCAND_W = 40;   // multiplicand magnitude
  localparam int MPLR_W  = 33;   // multiplier magnitude, also divisor width
  localparam int PROD_W  = MCAND_W + MPLR_W;
  localparam int QUOT_W  = 40;   // quotient bits produced per divide
  localparam int REM_W   = 34;   // partial remainder
  localparam int CNT_W   = 6;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TAU = 3'd5;

  // Command to the arithmetic unit
  typedef struct packed {
    logic start;
    logic div_sel;   // 1: divide, 0: multiply
  } alu_cmd_t;

  // Status back from the arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;      // one-cycle pulse, results held afterwards
    logic ovf;       // quotient does not fit in QUOT_W bits
  } alu_sts_t;

  // Saturate a 34-bit signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return signed'(v[31:0]);
    end
  endfunction

  // Magnitude of a 33-bit signed value (never called with the most negative value)
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    if (v[32]) begin
      return 33'(-v);
    end else begin
      return 33'(v);
    end
  endfunction

endpackage

### src/pdda_alu.sv
// Serial arithmetic unit: shift-add multiplier and restoring divider, one bit per cycle.
// Depends on pdda_pkg.
module pdda_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  pdda_pkg::alu_cmd_t                         cmd,
  input  logic [pdda_pkg::MCAND_W-1:0]               op_a,
  input  logic [pdda_pkg::MPLR_W-1:0]                op_b,
  input  logic [pdda_pkg::REM_W+FRAC_BITS-1:0]       op_n,
  output pdda_pkg::alu_sts_t                         sts,
  output logic [pdda_pkg::PROD_W-1:0]                prod,
  output logic [pdda_pkg::QUOT_W-1:0]                quot
);

  localparam int DIVN_W = pdda_pkg::REM_W + FRAC_BITS;
  localparam int HI_W   = DIVN_W - pdda_pkg::QUOT_W;

  logic [pdda_pkg::MCAND_W-1:0] mcand;
  logic [pdda_pkg::MCAND_W-1:0] acc;
  logic [pdda_pkg::MPLR_W-1:0]  lo;
  logic [pdda_pkg::MPLR_W-1:0]  divsr;
  logic [pdda_pkg::REM_W-1:0]   rem;
  logic [pdda_pkg::QUOT_W-1:0]  nq;
  logic [pdda_pkg::CNT_W-1:0]   cnt;
  logic                         div_mode;
  logic                         busy;
  logic                         done;
  logic                         ovf;

  logic [pdda_pkg::MCAND_W:0]   sum;
  logic [pdda_pkg::REM_W-1:0]   trial;
  logic [pdda_pkg::REM_W-1:0]   divsr_ext;
  logic                         fits;
  logic [HI_W-1:0]              hi;
  logic                         ovf_init;

  // One multiplier bit: add multiplicand if the low bit is set
  assign sum = {1'b0, acc} + {1'b0, (lo[0] ? mcand : '0)};

  // One quotient bit: shift in next dividend bit, trial subtract
  assign divsr_ext = {1'b0, divsr};
  assign trial     = {rem[pdda_pkg::REM_W-2:0], nq[pdda_pkg::QUOT_W-1]};
  assign fits      = (trial >= divsr_ext);

  // Upper dividend part must stay below the divisor for the quotient to fit
  assign hi       = op_n[DIVN_W-1:pdda_pkg::QUOT_W];
  assign ovf_init = (pdda_pkg::REM_W'(hi) >= {1'b0, op_b});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy     <= 1'b1;
        div_mode <= cmd.div_sel;
        if (cmd.div_sel) begin
          cnt   <= pdda_pkg::CNT_W'(pdda_pkg::QUOT_W);
          divsr <= op_b;
          rem   <= pdda_pkg::REM_W'(hi);
          nq    <= op_n[pdda_pkg::QUOT_W-1:0];
          ovf   <= ovf_init;
        end else begin
          cnt   <= pdda_pkg::CNT_W'(pdda_pkg::MPLR_W);
          mcand <= op_a;
          acc   <= '0;
          lo    <= op_b;
        end
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pdda_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        if (div_mode) begin
          rem <= fits ? (trial - divsr_ext) : trial;
          nq  <= {nq[pdda_pkg::QUOT_W-2:0], fits};
        end else begin
          acc <= sum[pdda_pkg::MCAND_W:1];
          lo  <= {sum[0], lo[pdda_pkg::MPLR_W-1:1]};
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign sts.ovf  = ovf;
  assign prod     = {acc, lo};
  assign quot     = nq;

endmodule

### src/pid_dirty_derivative_antiwindup_core.sv
// PID controller core with dirty-derivative filter and integrator back-calculation.
// Depends on pdda_pkg and pdda_alu.
//
// One input word is one control step and yields one drive word. Values are signed
// fixed point with FRAC_BITS fraction bits; controller sums saturate to 32 bits. Every
// multiply and divide runs on one shared serial unit that retires one bit per cycle,
// so a step takes two multiplies with a supplied rate and no integration, and up to
// six multiplies and three divides for a filtered derivative with integration and
// back-calculation. The input is stalled while a step is in progress; a finished
// drive word sits in an output register until taken.
// Registers are to be written through the cfg port only while the core is idle; the
// core does not enforce this itself, and cfg_ready is always high.
module pid_dirty_derivative_antiwindup_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // step input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [30:0]                         step_time,
  input  logic signed [31:0]                  measured,
  input  logic signed [31:0]                  target,
  input  logic                                integrate_enable,
  input  logic                                rate_supplied,
  input  logic signed [31:0]                  measured_rate,
  // drive output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  drive,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pdda_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int DIVN_W = pdda_pkg::REM_W + FRAC_BITS;
  // dt above 0.0001 s  <=>  dt > floor(2^F / 10000)
  localparam int DT_MIN = (1 << FRAC_BITS) / 10000;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_DA   = 4'd2;
  localparam logic [3:0] S_DB   = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_MPL  = 4'd6;
  localparam logic [3:0] S_MP   = 4'd7;
  localparam logic [3:0] S_MD   = 4'd8;
  localparam logic [3:0] S_ME   = 4'd9;
  localparam logic [3:0] S_MI   = 4'd10;
  localparam logic [3:0] S_SUM  = 4'd11;
  localparam logic [3:0] S_AW   = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0] state;

  // configuration
  logic [30:0]        gain_p;
  logic [30:0]        gain_i;
  logic [30:0]        gain_d;
  logic signed [31:0] out_max;
  logic signed [31:0] out_min;
  logic [30:0]        filter_tau;

  // controller state
  logic signed [31:0] integ_sum;
  logic signed [31:0] filt_der;
  logic signed [31:0] last_meas;

  // latched step word
  logic [30:0]        dt_r;
  logic signed [31:0] meas_r;
  logic signed [31:0] target_r;
  logic               integ_r;
  logic               rate_in_r;
  logic signed [31:0] mrate_r;

  // intermediate terms
  logic signed [31:0] err;
  logic signed [31:0] rate;
  logic signed [31:0] m1;
  logic signed [31:0] p_term;
  logic signed [31:0] d_term;
  logic signed [31:0] i_term;
  logic signed [31:0] u_sat;
  logic [pdda_pkg::QUOT_W-1:0] a_mag;
  logic                        a_neg;
  logic [pdda_pkg::QUOT_W-1:0] b_mag;

  // arithmetic unit operands
  pdda_pkg::alu_cmd_t          cmd;
  pdda_pkg::alu_sts_t          sts;
  logic [pdda_pkg::MCAND_W-1:0] op_a;
  logic [pdda_pkg::MPLR_W-1:0]  op_b;
  logic [DIVN_W-1:0]            op_n;
  logic                         op_neg;
  logic [pdda_pkg::PROD_W-1:0]  prod;
  logic [pdda_pkg::QUOT_W-1:0]  quot;

  pdda_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .op_a (op_a),
    .op_b (op_b),
    .op_n (op_n),
    .sts  (sts),
    .prod (prod),
    .quot (quot)
  );

  // Signed result from sign and magnitude, saturated to 32 bits
  function automatic logic signed [31:0] sat_mag(input logic neg, input logic big,
                                                 input logic [30:0] m);
    logic signed [31:0] v;
    v = signed'({1'b0, m});
    if (big) begin
      return neg ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      return neg ? -v : v;
    end
  endfunction

  logic signed [31:0] mul_res;
  logic signed [31:0] div_res;
  assign mul_res = sat_mag(op_neg, |prod[pdda_pkg::PROD_W-1:FRAC_BITS+31],
                           prod[FRAC_BITS+30:FRAC_BITS]);
  assign div_res = sat_mag(op_neg, sts.ovf | (|quot[pdda_pkg::QUOT_W-1:31]), quot[30:0]);

  // Filter coefficients: den = 2 tau + dt, numerator of a = 2 tau - dt
  logic [31:0]         twotau;
  logic [32:0]         den;
  logic signed [33:0]  tdiff;
  logic [32:0]         tdiff_mag;
  assign twotau    = {filter_tau, 1'b0};
  assign den       = 33'(twotau) + 33'(dt_r);
  assign tdiff     = signed'({2'b00, twotau}) - signed'({3'b000, dt_r});
  assign tdiff_mag = tdiff[33] ? 33'(-tdiff) : 33'(tdiff);

  // Measurement difference, kept exact
  logic signed [32:0] dx;
  assign dx = 33'(meas_r) - 33'(last_meas);

  // Sum, clamp and back-calculation room
  logic signed [31:0] u;
  logic signed [31:0] us;
  logic signed [33:0] room;
  logic [33:0]        room_mag;
  logic [32:0]        i_mag;
  assign u        = pdda_pkg::sat32(34'(p_term) - 34'(d_term) + 34'(i_term));
  assign us       = (u > out_max) ? out_max : ((u < out_min) ? out_min : u);
  assign room     = 34'(us) - 34'(p_term) + 34'(d_term);
  assign room_mag = room[33] ? 34'(-room) : 34'(room);
  assign i_mag    = pdda_pkg::mag33(33'(i_term));

  logic signed [31:0] fd_new;
  logic signed [31:0] isum_new;
  assign fd_new   = pdda_pkg::sat32(34'(m1) + 34'(mul_res));
  assign isum_new = pdda_pkg::sat32(34'(integ_sum) + 34'(mul_res));

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      cmd        <= '0;
      gain_p     <= '0;
      gain_i     <= '0;
      gain_d     <= '0;
      out_max    <= 32'sd65536;
      out_min    <= -32'sd65536;
      filter_tau <= 31'd3277;
      integ_sum  <= '0;
      filt_der   <= '0;
      last_meas  <= '0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pdda_pkg::CFG_GAIN_P:     gain_p     <= cfg_data[30:0];
          pdda_pkg::CFG_GAIN_I:     gain_i     <= cfg_data[30:0];
          pdda_pkg::CFG_GAIN_D:     gain_d     <= cfg_data[30:0];
          pdda_pkg::CFG_OUT_MAX:    out_max    <= signed'(cfg_data);
          pdda_pkg::CFG_OUT_MIN:    out_min    <= signed'(cfg_data);
          pdda_pkg::CFG_FILTER_TAU: filter_tau <= cfg_data[30:0];
          default: ;
        endcase
      end

      // drive word taken; S_OUT reloads it in the same cycle instead
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      // step sequencer; start is a one-cycle pulse, dropped in the first wait cycle
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            dt_r      <= step_time;
            meas_r    <= measured;
            target_r  <= target;
            integ_r   <= integrate_enable;
            rate_in_r <= rate_supplied;
            mrate_r   <= measured_rate;
            state     <= S_PREP;
          end
        end
        S_PREP: begin
          err <= pdda_pkg::sat32(34'(target_r) - 34'(meas_r));
          if (rate_in_r) begin
            rate  <= mrate_r;
            state <= S_MPL;
          end else if (dt_r > 31'(DT_MIN)) begin
            // a = (2 tau - dt) 2^F / den
            op_n        <= DIVN_W'(tdiff_mag) << FRAC_BITS;
            op_b        <= den;
            op_neg      <= tdiff[33];
            cmd.start   <= 1'b1;
            cmd.div_sel <= 1'b1;
            state       <= S_DA;
          end else begin
            rate      <= '0;
            last_meas <= meas_r;
            state     <= S_MPL;
          end
        end
        S_DA: begin
          if (sts.done) begin
            a_mag <= quot;
            a_neg <= op_neg;
            // b = 2^(2F+1) / den
            op_n        <= DIVN_W'(1) << (2 * FRAC_BITS + 1);
            op_b        <= den;
            op_neg      <= 1'b0;
            cmd.start   <= 1'b1;
            cmd.div_sel <= 1'b1;
            state       <= S_DB;
          end else begin
            cmd.start <= 1'b0;
          end
        end
        S_DB: begin
          if (sts.done) begin
            b_mag       <= quot;
            op_a        <= a_mag;
            op_b        <= pdda_pkg::mag33(33'(filt_der));
            op_neg      <= a_neg ^ filt_der[31];
            cmd.start   <= 1'b1;
            cmd.div_sel <= 1'b0;
            state       <= S_M1;
          end else begin
            cmd.start <= 1'b0;
          end
        end
        S_M1: begin
          if (sts.done) begin
            m1          <= mul_res;
            op_a        <= b_mag;
            op_b        <= pdda_pkg::mag33(dx);
            op_neg      <= dx[32];
            cmd.start   <= 1'b1;
            cmd.div_sel <= 1'b0;
            state       <= S_M2;
          end else begin
            cmd.start <= 1'b0;
          end
        end
        S_M2: begin
          if (sts.done) begin
            filt_der  <= fd_new;
            rate      <= fd_new;
            last_meas <= meas_r;
            state     <= S_MPL;
          end else begin
            cmd.start <= 1'b0;
          end
        end
        S_MPL: begin
          op_a        <= pdda_pkg::MCAND_W'(gain_p);
          op_b        <= pdda_pkg::mag33(33'(err));
          op_neg      <= err[31];
          cmd.start   <= 1'b1;
          cmd.div_sel <= 1'b0;
          state       <= S_MP;
        end
        S_MP: begin
          if (sts.done) begin
            p_term      <= mul_res;
            op_a        <= pdda_pkg::MCAND_W'(gain_d);
            op_b        <= pdda_pkg::mag33(33'(rate));
            op_neg      <= rate[31];
            cmd.start   <= 1'b1;
            cmd.div_sel <= 1'b0;
            state       <= S_MD;
          end else begin
            cmd.start <= 1'b0;
          end
        end
        S_MD: begin
          if (sts.done) begin
            d_term <= mul_res;
            if (integ_r && (gain_i != '0)) begin
              op_a        <= pdda_pkg::MCAND_W'(dt_r);
              op_b        <= pdda_pkg::mag33(33'(err));
              op_neg      <= err[31];
              cmd.start   <= 1'b1;
              cmd.div_sel <= 1'b0;
              state       <= S_ME;
            end else begin
              i_term <= '0;
              state  <= S_SUM;
            end
          end else begin
            cmd.start <= 1'b0;
          end
        end
        S_ME: begin
          if (sts.done) begin
            integ_sum   <= isum_new;
            op_a        <= pdda_pkg::MCAND_W'(gain_i);
            op_b        <= pdda_pkg::mag33(33'(isum_new));
            op_neg      <= isum_new[31];
            cmd.start   <= 1'b1;
            cmd.div_sel <= 1'b0;
            state       <= S_MI;
          end else begin
            cmd.start <= 1'b0;
          end
        end
        S_MI: begin
          if (sts.done) begin
            i_term <= mul_res;
            state  <= S_SUM;
          end else begin
            cmd.start <= 1'b0;
          end
        end
        S_SUM: begin
          u_sat <= us;
          // back-calculate integrator when clamped and I dominates the room
          if ((u != us) && (gain_i != '0) && (34'(i_mag) > room_mag)) begin
            op_n        <= DIVN_W'(room_mag) << FRAC_BITS;
            op_b        <= pdda_pkg::MPLR_W'(gain_i);
            op_neg      <= room[33];
            cmd.start   <= 1'b1;
            cmd.div_sel <= 1'b1;
            state       <= S_AW;
          end else begin
            state <= S_OUT;
          end
        end
        S_AW: begin
          if (sts.done) begin
            integ_sum <= div_res;
            state     <= S_OUT;
          end else begin
            cmd.start <= 1'b0;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            drive     <= u_sat;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The serial unit is never restarted while it is still working
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !sts.busy)
    else $error("arithmetic unit started while busy");

  // Completion always follows a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> $past(sts.busy))
    else $error("arithmetic unit done without work");

  // No arithmetic in flight while waiting for a new step
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!sts.busy && !cmd.start))
    else $error("arithmetic active in idle");

endmodule

### sim/testbench.sv
// Self-checking testbench for pid_dirty_derivative_antiwindup_core.
// Depends on pdda_pkg and the core RTL; a built-in PID step model predicts each drive word.
`timescale 1ns / 100ps

module testbench;

  localparam int FB = 16;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [30:0] step_time = '0;
  logic signed [31:0] measured = '0;
  logic signed [31:0] target = '0;
  logic integrate_enable = 1'b0;
  logic rate_supplied = 1'b0;
  logic signed [31:0] measured_rate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] drive;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pdda_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pid_dirty_derivative_antiwindup_core #(.FRAC_BITS(FB)) dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  typedef struct {
    logic [30:0] dt;
    logic signed [31:0] x;
    logic signed [31:0] sp;
    logic integ;
    logic rsel;
    logic signed [31:0] rate;
    logic has_exp;
    logic signed [31:0] exp_drive;
  } step_row_t;

  // Controller copy kept by the testbench
  longint kp, ki, kd, tau, umax, umin;
  longint isum, dfilt, xlast;

  logic signed [31:0] drive_q[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic longint sat_w(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q-format multiply truncated toward zero, saturated
  function automatic longint qmul(longint a, longint b);
    logic [127:0] pr;
    logic [63:0] ma, mb;
    longint r;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    pr = (ma * 128'd1 * mb) >> FB;
    if (pr > (128'd1 << 40)) pr = 128'd1 << 40;
    r = longint'(pr[63:0]);
    return sat_w(((a < 0) != (b < 0)) ? -r : r);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [31:0] pid_step(step_row_t s);
    longint dtv, rate, err, p, d, i, u, us, room, twotau, den, a, b;
    dtv = s.dt;
    d = 0;
    i = 0;
    if (s.rsel) begin
      rate = s.rate;
    end else begin
      if (dtv * 10000 > (64'sd1 << FB)) begin
        twotau = 2 * tau;
        den = twotau + dtv;
        a = ((twotau - dtv) * (64'sd1 << FB)) / den;
        b = (64'sd1 << (2 * FB + 1)) / den;
        dfilt = sat_w(qmul(a, dfilt) + qmul(b, longint'(s.x) - xlast));
        rate = dfilt;
      end else begin
        rate = 0;
      end
      xlast = s.x;
    end
    err = sat_w(longint'(s.sp) - longint'(s.x));
    p = qmul(err, kp);
    if (kd > 0) d = qmul(kd, rate);
    if (ki > 0 && s.integ) begin
      isum = sat_w(isum + qmul(err, dtv));
      i = qmul(ki, isum);
    end
    u = sat_w(p - d + i);
    us = (u > umax) ? umax : (u < umin) ? umin : u;
    room = us - p + d;
    // back-calculate integrator when the clamp bites
    if (u != us && ki > 0 && absl(i) > absl(room))
      isum = sat_w((room * (64'sd1 << FB)) / ki);
    return us[31:0];
  endfunction

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [pdda_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pdda_pkg::CFG_GAIN_P: kp = val[30:0];
      pdda_pkg::CFG_GAIN_I: ki = val[30:0];
      pdda_pkg::CFG_GAIN_D: kd = val[30:0];
      pdda_pkg::CFG_OUT_MAX: umax = longint'(signed'(val));
      pdda_pkg::CFG_OUT_MIN: umin = longint'(signed'(val));
      pdda_pkg::CFG_FILTER_TAU: tau = val[30:0];
      default: ;
    endcase
  endtask

  // Drop the input, wait until every drive word is back, then let the core settle
  task automatic drain();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Valid stays high after acceptance; the next word or drain() replaces it
  task automatic send_step(step_row_t s);
    logic signed [31:0] pred;
    int gap;
    gap = $urandom_range(0, 11) * int'($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    step_time <= s.dt;
    measured <= s.x;
    target <= s.sp;
    integrate_enable <= s.integ;
    rate_supplied <= s.rsel;
    measured_rate <= s.rate;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = pid_step(s);
    if (s.has_exp && pred !== s.exp_drive) begin
      $display("%0t model disagrees with table: expected %0d predicted %0d",
               $time, s.exp_drive, pred);
      errors++;
    end
    drive_q.push_back(s.has_exp ? s.exp_drive : pred);
  endtask

  function automatic step_row_t rnd_step();
    step_row_t s;
    s.dt = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 6554));
    s.x = ($urandom_range(0, 4) == 0) ? $urandom : $signed($urandom_range(0, 262144)) - 131072;
    s.sp = ($urandom_range(0, 4) == 0) ? $urandom : $signed($urandom_range(0, 262144)) - 131072;
    s.integ = $urandom_range(0, 1);
    s.rsel = $urandom_range(0, 1);
    s.rate = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 262144)) - 131072;
    s.has_exp = 1'b0;
    s.exp_drive = '0;
    return s;
  endfunction

  // Directed steps: dt, x, setpoint, integ, rate_sel, rate, has_exp, expected
  step_row_t directed[] = '{
    '{31'd0, 32'sd0, 32'sd0, 1'b0, 1'b0, 32'sd0, 1'b1, 32'sd0},
    '{31'h7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b1, 1'b0, 32'sh7fffffff, 1'b0, 32'sd0},
    '{31'd6, 32'sh80000000, 32'sh7fffffff, 1'b1, 1'b0, 32'sh80000000, 1'b0, 32'sd0},
    '{31'd7, 32'sd65536, 32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0, 32'sd0},
    '{31'd655, 32'sd1000, 32'sd5000, 1'b1, 1'b1, 32'sh80000000, 1'b0, 32'sd0},
    '{31'd6554, 32'sh7fffffff, 32'sh80000000, 1'b1, 1'b0, 32'sd0, 1'b0, 32'sd0},
    '{31'd1311, 32'sh80000000, 32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff, 1'b0, 32'sd0},
    '{31'd65536, 32'sd0, 32'sd65536, 1'b1, 1'b0, 32'sd0, 1'b0, 32'sd0},
    '{31'h55555555, 32'sh2aaaaaaa, 32'sh55555555, 1'b0, 1'b1, 32'sh2aaaaaaa, 1'b0, 32'sd0}
  };

  // Gain/clamp sets: p, i, d, max, min, tau
  logic [31:0] cfg_sets[5][6] = '{
    '{32'd65536, 32'd6554, 32'd655, 32'd65536, -32'sd65536, 32'd3277},
    '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff},
    '{32'd1, 32'd1, 32'd1, 32'h80000000, 32'h7fffffff, 32'd1},
    '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd200000, 32'd30000, 32'd5000, 32'd131072, -32'sd40000, 32'd1000}
  };

  // Result checker and stall generator
  int stall_wait = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (drive_q.size() == 0) begin
          $display("%0t unexpected drive word: expected none actual %0d", $time, drive);
          errors++;
        end else begin
          if (drive !== drive_q[0]) begin
            $display("%0t drive mismatch: expected %0d actual %0d",
                     $time, drive_q[0], drive);
            errors++;
          end
          void'(drive_q.pop_front());
        end
        stall_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end
      if (stall_wait > 0) begin
        out_stall <= 1'b1;
        stall_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    step_row_t s;
    kp = 0; ki = 0; kd = 0; umax = 65536; umin = -65536; tau = 3277;
    isum = 0; dfilt = 0; xlast = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings first, then the directed table under the first gain set
    send_step(directed[0]);
    drain();
    for (int k = 0; k < 6; k++) write_reg(k[pdda_pkg::CFG_IDX_W-1:0], cfg_sets[0][k]);
    cfg_valid <= 1'b0;
    foreach (directed[n]) begin
      s = directed[n];
      if (n == 0) s.has_exp = 1'b0;
      send_step(s);
    end
    drain();

    // random phases across every gain set
    for (int ph = 0; ph < 10; ph++) begin
      for (int k = 0; k < 6; k++)
        write_reg(k[pdda_pkg::CFG_IDX_W-1:0], cfg_sets[ph % 5][k]);
      cfg_valid <= 1'b0;
      for (int n = 0; n < 90; n++) begin
        send_step(rnd_step());
        if (n == 45) drain();
      end
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
